>>> sv/stroke_font_text_plotter_macros.svh
// Assertion macros used by the checker of the plotter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STROKE_FONT_TEXT_PLOTTER_MACROS_SVH
`define STROKE_FONT_TEXT_PLOTTER_MACROS_SVH

// The consequence must hold in the cycle after the antecedent.
`define SFTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequence must hold in the same cycle as the antecedent.
`define SFTP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/sftp_pkg.sv
package sftp_pkg;

    localparam int DEF_TABLE_DEPTH = 2048;
    localparam int DEF_MAX_STROKES = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic signed [15:0] HEADER_MARK = 16'sd999;
    localparam logic signed [15:0] GAP_UNITS   = 16'sd5;
    localparam logic [7:0]         CODE_CR     = 8'd13;
    localparam logic [7:0]         CODE_LF     = 8'd10;
    localparam logic [15:0]        SCALE_RESET = 16'd2048;

    typedef struct packed {
        logic signed [15:0] third;
        logic signed [15:0] second;
        logic signed [15:0] first;
    } glyph_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_MULX,
        ST_MULY,
        ST_EMIT,
        ST_ADV_MUL,
        ST_ADV_ADD,
        ST_LF_MUL,
        ST_LF_ADD,
        ST_FINISH
    } state_t;

    // Divides a product by 256, rounding toward zero.
    function automatic logic [31:0] scale_trunc(input logic signed [31:0] p);
        logic signed [31:0] adj;
        adj = p[31] ? (p + 32'sd255) : p;
        return adj >>> 8;
    endfunction

endpackage

>>> sv/stroke_font_text_plotter.sv
// A load, carriage return or unknown op is done in idle; a line feed runs LF_MUL, LF_ADD.
// A character scans the glyph memory at one word per cycle until the header or last entry,
// then runs FETCH, MULX, MULY, EMIT per stroke word on the shared multiplier, EMIT waiting
// on a stalled output, then ADV_MUL, ADV_ADD to advance X; no item is taken while it works.
// rst_n is asynchronous and active low; it clears the cursor and control state and sets the scale to SCALE_RESET.
// The glyph memory is not cleared by reset.
module stroke_font_text_plotter #(
    parameter int TABLE_DEPTH = sftp_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_STROKES = sftp_pkg::DEF_MAX_STROKES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: entry_index[10:0], word_first[26:11], word_second[42:27],
    // word_third[58:43], char_code[66:59], zero fill[71:67].
    input  logic [71:0] s_axis_tdata,
    // tuser: op[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: target_x[31:0], target_y[63:32].
    output logic [63:0] m_axis_tdata,
    // tuser: pen_down[0].
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import sftp_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(MAX_STROKES + 1);
    localparam int CW = (AW > 15) ? AW + 1 : 16;

    logic [10:0]        in_index;
    logic signed [15:0] in_first;
    logic signed [15:0] in_second;
    logic signed [15:0] in_third;
    logic [7:0]         in_code;
    logic               in_accept;

    assign in_index  = s_axis_tdata[10:0];
    assign in_first  = s_axis_tdata[26:11];
    assign in_second = s_axis_tdata[42:27];
    assign in_third  = s_axis_tdata[58:43];
    assign in_code   = s_axis_tdata[66:59];

    glyph_word_t mem [TABLE_DEPTH];
    glyph_word_t rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    state_t state_reg, state_next;

    logic [15:0]        scale_reg;
    logic [31:0]        pen_x_reg, pen_x_next;
    logic [31:0]        pen_y_reg, pen_y_next;
    logic [7:0]         code_reg, code_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      chk_addr_reg, chk_addr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [NW-1:0]      n_reg, n_next;
    logic signed [15:0] max_x_reg, max_x_next;
    logic signed [15:0] mul_a;
    logic               prod_en;
    logic signed [31:0] prod_reg, prod_next;
    logic [31:0]        tx_reg, tx_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_pen_reg, out_pen_next;
    logic [31:0]        out_x_reg, out_x_next;
    logic [31:0]        out_y_reg, out_y_next;
    logic               out_last_reg, out_last_next;
    logic               out_free;

    logic               hit;
    logic               scan_end;
    logic [CW-1:0]      cnt_third;
    logic [CW-1:0]      cnt_room;
    logic [CW-1:0]      cnt_lim;
    logic [NW-1:0]      hit_n;
    logic               run_last;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_pen_reg;
    assign m_axis_tlast  = out_last_reg;

    assign mem_we = in_accept && (s_axis_tuser == OP_LOAD) && (32'(in_index) < TABLE_DEPTH);
    assign rd_addr = (state_reg == ST_SCAN) ? addr_reg : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(in_index)] <= {in_third, in_second, in_first};
        end
        rdata_reg <= mem[rd_addr];
    end

    assign hit = chk_valid_reg && (rdata_reg.first == HEADER_MARK)
                 && (rdata_reg.second == {8'd0, code_reg});
    assign scan_end = chk_valid_reg && (chk_addr_reg == AW'(TABLE_DEPTH - 1));

    always_comb
    begin
        cnt_third = rdata_reg.third[15] ? '0 : CW'(unsigned'(rdata_reg.third[14:0]));
        cnt_room  = CW'(TABLE_DEPTH - 1) - CW'(chk_addr_reg);
        cnt_lim   = CW'(MAX_STROKES);
        if (cnt_room < cnt_lim)
        begin
            cnt_lim = cnt_room;
        end
        if (cnt_third < cnt_lim)
        begin
            cnt_lim = cnt_third;
        end
        hit_n = NW'(cnt_lim);
    end

    assign run_last = (cnt_reg == (n_reg - NW'(1)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (s_axis_tuser)
                        OP_CHAR:
                        begin
                            if (in_code == CODE_LF)
                            begin
                                state_next = ST_LF_MUL;
                            end
                            else if (in_code != CODE_CR)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_FINISH: state_next = ST_FINISH;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = (hit_n == '0) ? ST_ADV_MUL : ST_FETCH;
                end
                else if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:   state_next = ST_MULX;
            ST_MULX:    state_next = ST_MULY;
            ST_MULY:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = run_last ? ST_ADV_MUL : ST_FETCH;
                end
            end
            ST_ADV_MUL: state_next = ST_ADV_ADD;
            ST_ADV_ADD: state_next = ST_IDLE;
            ST_LF_MUL:  state_next = ST_LF_ADD;
            ST_LF_ADD:  state_next = ST_IDLE;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        code_next      = code_reg;
        addr_next      = addr_reg;
        chk_addr_next  = chk_addr_reg;
        chk_valid_next = chk_valid_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        max_x_next     = max_x_reg;
        tx_next        = tx_reg;
        mul_a          = rdata_reg.first;
        prod_en        = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_pen_next   = out_pen_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                addr_next      = '0;
                chk_valid_next = 1'b0;
                code_next      = in_code;
                if (in_accept && (s_axis_tuser == OP_CHAR) && (in_code == CODE_CR))
                begin
                    pen_x_next = '0;
                end
            end
            ST_SCAN:
            begin
                addr_next      = addr_reg + AW'(1);
                chk_addr_next  = addr_reg;
                chk_valid_next = 1'b1;
                ptr_next       = chk_addr_reg + AW'(1);
                n_next         = hit_n;
                cnt_next       = '0;
                max_x_next     = '0;
            end
            ST_MULX:
            begin
                mul_a   = rdata_reg.first;
                prod_en = 1'b1;
                if (rdata_reg.first > max_x_reg)
                begin
                    max_x_next = rdata_reg.first;
                end
            end
            ST_MULY:
            begin
                mul_a   = rdata_reg.second;
                prod_en = 1'b1;
                tx_next = pen_x_reg + scale_trunc(prod_reg);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pen_next   = (rdata_reg.third != '0);
                    out_x_next     = tx_reg;
                    out_y_next     = pen_y_reg + scale_trunc(prod_reg);
                    out_last_next  = run_last;
                    cnt_next       = cnt_reg + NW'(1);
                    ptr_next       = ptr_reg + AW'(1);
                end
            end
            ST_ADV_MUL:
            begin
                mul_a   = max_x_reg;
                prod_en = 1'b1;
            end
            ST_ADV_ADD:
            begin
                pen_x_next = pen_x_reg + scale_trunc(prod_reg) + 32'(GAP_UNITS);
            end
            ST_LF_MUL:
            begin
                mul_a   = GAP_UNITS;
                prod_en = 1'b1;
            end
            ST_LF_ADD:
            begin
                pen_y_next = pen_y_reg - scale_trunc(prod_reg);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pen_next   = 1'b0;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
                mul_a = rdata_reg.first;
            end
        endcase
    end

    assign prod_next = mul_a * $signed({1'b0, scale_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_RESET;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        addr_reg     <= addr_next;
        chk_addr_reg <= chk_addr_next;
        ptr_reg      <= ptr_next;
        cnt_reg      <= cnt_next;
        n_reg        <= n_next;
        max_x_reg    <= max_x_next;
        tx_reg       <= tx_next;
        out_pen_reg  <= out_pen_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
        if (prod_en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

>>> sv/sftp_checker.sv
`include "stroke_font_text_plotter_macros.svh"

module sftp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    import sftp_pkg::*;

    logic in_accept;
    logic out_accept;
    logic out_stall;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;

    // A stalled result word keeps its valid and its payload.
    `SFTP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result word changed")

    // A finish word keeps the block busy until its result word is loaded for output.
    `SFTP_ASSERT_NEXT(a_finish_busy, in_accept && (s_axis_tuser == OP_FINISH), !s_axis_tready, "block ready right after a finish word")

    // A stroke run that is not yet complete keeps the input side closed.
    `SFTP_ASSERT_NEXT(a_run_busy, out_accept && !m_axis_tlast, !s_axis_tready, "input accepted in the middle of a stroke run")

    // Configuration writes are never refused.
    `SFTP_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready || !rst_n, "configuration write refused")

endmodule

bind stroke_font_text_plotter sftp_checker u_sftp_checker (.*);

>>> tb/sv/stroke_font_text_plotter_tb.sv
`timescale 1ns / 100ps

module stroke_font_text_plotter_tb;
    import sftp_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int MAX_STROKES = DEF_MAX_STROKES;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 4 * MAX_STROKES + 64;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 24;

    typedef struct packed {
        logic        pen_down;
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } pen_cmd_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [10:0]        idx;
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic signed [15:0] third;
        logic [7:0]         code;
        logic               typed;
        pen_cmd_t           want;
    } stim_row_t;

    localparam pen_cmd_t NO_CMD = '0;

    localparam stim_row_t DIRECTED [25] = '{
        '{OP_FINISH, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b1}},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd65, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd0, 16'sd999, 16'sd65, 16'sd1, 8'd0, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd1, 16'sd3, -16'sd2, 16'sd1, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd65, 1'b1,
          '{1'b1, 32'd24, -32'sd16, 1'b1}},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, CODE_CR, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, CODE_LF, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd2, 16'sd999, 16'sd66, 16'sd3, 8'd0, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd3, 16'sh7FFF, 16'sh7FFF, 16'sd0, 8'd0, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd4, 16'sh8000, 16'sh8000, 16'sd7, 8'd0, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd5, 16'sd0, 16'sd0, -16'sd1, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd66, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd6, 16'sd999, 16'sd67, 16'sd0, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd67, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd7, 16'sd999, 16'sd68, 16'sh8000, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd68, 1'b0, NO_CMD},
        '{OP_LOAD, 11'h7FF, 16'sd999, 16'sd255, 16'sd5, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd255, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd8, 16'sd999, 16'sd0, 16'sh7FFF, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, NO_CMD},
        '{OP_UNUSED, 11'h7FF, -16'sd1, -16'sd1, -16'sd1, 8'hFF, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd2040, 16'sd999, 16'sd200, 16'sd20, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd200, 1'b0, NO_CMD},
        '{OP_LOAD, 11'd9, 16'sd999, 16'sd65, 16'sd2, 8'd0, 1'b0, NO_CMD},
        '{OP_CHAR, 11'd0, 16'sd0, 16'sd0, 16'sd0, 8'd65, 1'b0, NO_CMD}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    glyph_word_t font_mem [TABLE_DEPTH];
    logic [31:0] cursor_x;
    logic [31:0] cursor_y;
    logic [15:0] scale_reg;
    pen_cmd_t    item_cmds [$];
    pen_cmd_t    pending_cmds [$];
    int          errors;
    bit          no_gaps;
    bit          hold_off;

    stroke_font_text_plotter dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] scale_mul(input logic signed [31:0] v);
        longint prod;
        prod = longint'(v) * longint'({1'b0, scale_reg});
        return 32'(prod / 256);
    endfunction

    function automatic void plot_item(input logic [1:0] op, input logic [10:0] idx,
                                      input logic signed [15:0] first,
                                      input logic signed [15:0] second,
                                      input logic signed [15:0] third,
                                      input logic [7:0] code);
        int hdr;
        int n;
        logic signed [31:0] widest;
        glyph_word_t pt;
        item_cmds.delete();
        hdr = -1;
        widest = 0;
        case (op)
            OP_LOAD:
            begin
                font_mem[idx].first  = first;
                font_mem[idx].second = second;
                font_mem[idx].third  = third;
            end
            OP_CHAR:
            begin
                if (code == CODE_CR)
                    cursor_x = '0;
                else if (code == CODE_LF)
                    cursor_y = cursor_y - scale_mul(GAP_UNITS);
                else
                begin
                    for (int h = 0; h < TABLE_DEPTH && hdr < 0; h++)
                        if (font_mem[h].first == HEADER_MARK && font_mem[h].second == {8'h00, code})
                            hdr = h;
                    if (hdr >= 0)
                    begin
                        n = font_mem[hdr].third;
                        if (n < 0)
                            n = 0;
                        if (n > MAX_STROKES)
                            n = MAX_STROKES;
                        if (n > TABLE_DEPTH - 1 - hdr)
                            n = TABLE_DEPTH - 1 - hdr;
                        for (int k = 0; k < n; k++)
                        begin
                            pt = font_mem[hdr + 1 + k];
                            if (pt.first > widest)
                                widest = pt.first;
                            item_cmds.push_back(pen_cmd_t'{pt.third != 0,
                                                           cursor_x + scale_mul(pt.first),
                                                           cursor_y + scale_mul(pt.second),
                                                           k == n - 1});
                        end
                        cursor_x = cursor_x + scale_mul(widest) + 32'(GAP_UNITS);
                    end
                end
            end
            OP_FINISH:
                item_cmds.push_back(pen_cmd_t'{1'b0, 32'd0, 32'd0, 1'b1});
            default:
                ;
        endcase
    endfunction

    task automatic offer_item(input logic [1:0] op, input logic [10:0] idx,
                              input logic signed [15:0] first,
                              input logic signed [15:0] second,
                              input logic signed [15:0] third,
                              input logic [7:0] code, input logic typed,
                              input pen_cmd_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tuser  = op;
        s_axis_tdata  = {5'd0, code, third, second, first, idx};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        plot_item(op, idx, first, second, third, code);
        if (typed)
            pending_cmds.push_back(want);
        else
            foreach (item_cmds[i])
                pending_cmds.push_back(item_cmds[i]);
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : rx_side
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                    m_axis_tready = 1'b1;
                else
                begin
                    m_axis_tready = 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_cmds
        pen_cmd_t seen;
        pen_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast};
            if (pending_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: no word expected, got pen %0b x %0d y %0d last %0b", $time,
                         seen.pen_down, $signed(seen.x), $signed(seen.y), seen.last);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (seen !== want)
                begin
                    errors++;
                    $display("%0t: expected pen %0b x %0d y %0d last %0b, got pen %0b x %0d y %0d last %0b",
                             $time, want.pen_down, $signed(want.x), $signed(want.y), want.last,
                             seen.pen_down, $signed(seen.x), $signed(seen.y), seen.last);
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("stroke_font_text_plotter: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]         glyph_codes [3];
        logic [7:0]         pick;
        logic signed [15:0] rand_first;
        logic [15:0]        new_scale;
        int                 n_glyphs;
        int                 base;
        int                 cnt;
        int                 r;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        errors        = 0;
        no_gaps       = 1'b0;
        hold_off      = 1'b0;
        cursor_x      = '0;
        cursor_y      = '0;
        scale_reg     = SCALE_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every table word is written first, so the header scan never reads an unwritten word.
        no_gaps = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rand_first = 16'($urandom);
            if (rand_first == HEADER_MARK)
                rand_first = '0;
            offer_item(OP_LOAD, 11'(i), rand_first, 16'($urandom), 16'($urandom), 8'($urandom),
                       1'b0, NO_CMD);
        end
        no_gaps = 1'b0;

        foreach (DIRECTED[i])
            offer_item(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].first, DIRECTED[i].second,
                       DIRECTED[i].third, DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: new_scale = 16'hFFFF;
                1: new_scale = 16'd0;
                2: new_scale = 16'd1;
                3: new_scale = 16'd256;
                default: new_scale = 16'($urandom_range(64, 4096));
            endcase
            @(negedge clk);
            cfg_data  = new_scale;
            cfg_valid = 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            scale_reg = new_scale;
            @(negedge clk);
            cfg_valid = 1'b0;
            no_gaps = (p == 3);

            n_glyphs = $urandom_range(2, 3);
            for (int g = 0; g < n_glyphs; g++)
            begin
                do
                    pick = 8'($urandom);
                while (pick == CODE_CR || pick == CODE_LF);
                glyph_codes[g] = pick;
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(13, MAX_STROKES)
                                                  : $urandom_range(1, 12);
                base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                                   : $urandom_range(0, 200);
                if (base > TABLE_DEPTH - 1 - cnt)
                    base = TABLE_DEPTH - 1 - cnt;
                offer_item(OP_LOAD, 11'(base), HEADER_MARK, {8'h00, pick}, 16'(cnt),
                           8'($urandom), 1'b0, NO_CMD);
                for (int k = 1; k <= cnt; k++)
                    offer_item(OP_LOAD, 11'(base + k),
                               ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 120)) - 16'sd60,
                               ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 120)) - 16'sd60,
                               ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 1)),
                               8'($urandom), 1'b0, NO_CMD);
            end

            if (p == 4)
                hold_off = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    pick = glyph_codes[$urandom_range(0, n_glyphs - 1)];
                else if (r < 63)
                    pick = CODE_CR;
                else if (r < 71)
                    pick = CODE_LF;
                else
                    pick = 8'($urandom);
                if (r < 83)
                    offer_item(OP_CHAR, 11'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), pick, 1'b0, NO_CMD);
                else if (r < 88)
                    offer_item(OP_FINISH, 11'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 8'($urandom), 1'b0, NO_CMD);
                else if (r < 95)
                    offer_item(OP_LOAD, 11'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 8'($urandom), 1'b0, NO_CMD);
                else
                    offer_item(OP_UNUSED, 11'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 8'($urandom), 1'b0, NO_CMD);
            end
        end

        settle();
        if (errors == 0)
            $display("stroke_font_text_plotter: match");
        else
            $display("stroke_font_text_plotter: mismatch");
        $finish;
    end

endmodule
